// File: rtl/bst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types, constants and character helpers for the source tokenizer.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int FIFO_DEPTH        = 4;
  localparam int FIFO_PTR_BITS     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS     = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_APOS       = 8'h27;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;

  localparam logic [2:0] KW_LEN_DEF   = 3'd3;
  localparam logic [2:0] KW_LEN_PRINT = 3'd5;
  localparam logic [2:0] KW_LEN_IF    = 3'd2;
  localparam logic [2:0] IDENT_SAT    = 3'd6;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NUM     = 3'd1,
    MODE_IDENT   = 3'd2,
    MODE_STR     = 3'd3,
    MODE_COMMENT = 3'd4,
    MODE_HALT    = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    TK_EOF    = 4'd0,
    TK_IDENT  = 4'd1,
    TK_INT    = 4'd2,
    TK_STRING = 4'd3,
    TK_DEF    = 4'd4,
    TK_PRINT  = 4'd5,
    TK_IF     = 4'd6,
    TK_ASSIGN = 4'd7,
    TK_PLUS   = 4'd8,
    TK_MINUS  = 4'd9,
    TK_MUL    = 4'd10,
    TK_DIV    = 4'd11,
    TK_LPAREN = 4'd12,
    TK_RPAREN = 4'd13,
    TK_COMMA  = 4'd14,
    TK_ERROR  = 4'd15
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        ovf;
    logic        last;
  } res_t;

  typedef struct packed {
    mode_t mode;
    logic  ovf;
  } lex_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic tok_kind_t punct_kind(input logic [7:0] c);
    tok_kind_t k;
    case (c)
      8'h3D:   k = TK_ASSIGN;
      8'h2B:   k = TK_PLUS;
      8'h2D:   k = TK_MINUS;
      8'h2A:   k = TK_MUL;
      8'h2F:   k = TK_DIV;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h2C:   k = TK_COMMA;
      default: k = TK_ERROR;
    endcase
    return k;
  endfunction

  // bit0 DEF, bit1 PRINT, bit2 IF; a set bit means keyword i can no longer match
  function automatic logic [2:0] kw_miss(input logic [2:0] k, input logic [7:0] c);
    logic [2:0] miss;
    miss = 3'b111;
    case (k)
      3'd0: begin
        miss[0] = (c != 8'h44);
        miss[1] = (c != 8'h50);
        miss[2] = (c != 8'h49);
      end
      3'd1: begin
        miss[0] = (c != 8'h45);
        miss[1] = (c != 8'h52);
        miss[2] = (c != 8'h46);
      end
      3'd2: begin
        miss[0] = (c != 8'h46);
        miss[1] = (c != 8'h49);
      end
      3'd3: begin
        miss[1] = (c != 8'h4E);
      end
      3'd4: begin
        miss[1] = (c != 8'h54);
      end
      default: miss = 3'b111;
    endcase
    return miss;
  endfunction

  function automatic tok_kind_t ident_kind(input logic [2:0] mask, input logic [2:0] seen);
    tok_kind_t k;
    k = TK_IDENT;
    if (mask[0] && (seen == KW_LEN_DEF))   k = TK_DEF;
    if (mask[1] && (seen == KW_LEN_PRINT)) k = TK_PRINT;
    if (mask[2] && (seen == KW_LEN_IF))    k = TK_IF;
    return k;
  endfunction

endpackage

// File: rtl/bst_lex_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_lex_core
// Lexer state and per-byte mode update; yields up to two results per item.
// ----------------------------------------------------------------------------
module bst_lex_core import bst_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic [1:0]  push_n,
  output res_t        rec0,
  output res_t        rec1,
  output lex_status_t status
);

  localparam int WIDE = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  function automatic logic [15:0] to16(input logic [POSITION_BITS-1:0] v);
    logic [WIDE-1:0] t;
    t = WIDE'(v);
    return t[15:0];
  endfunction

  mode_t                    mode, mode_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] tbeg, tbeg_next;
  logic [2:0]               mask, mask_next;
  logic [2:0]               seen, seen_next;
  logic                     ovf, ovf_next;

  logic                     at_max;
  logic                     run_idle;
  logic                     close_vld, idle_vld;
  tok_kind_t                close_kind, idle_kind;
  logic [POSITION_BITS-1:0] close_len, idle_len, str_len, tok_len;
  logic                     rec_ovf;
  res_t                     close_rec, idle_rec;

  assign at_max  = (pos == POS_MAX);
  assign tok_len = pos - tbeg;
  assign str_len = (pos >= tbeg) ? tok_len : '0;

  always_comb begin
    mode_next  = mode;
    pos_next   = pos;
    tbeg_next  = tbeg;
    mask_next  = mask;
    seen_next  = seen;
    ovf_next   = ovf;
    run_idle   = 1'b0;
    close_vld  = 1'b0;
    close_kind = TK_EOF;
    close_len  = tok_len;
    idle_vld   = 1'b0;
    idle_kind  = TK_EOF;
    idle_len   = POSITION_BITS'(1);
    rec_ovf    = ovf;
    if (end_of_text) begin
      case (mode)
        MODE_NUM: begin
          close_vld  = 1'b1;
          close_kind = TK_INT;
        end
        MODE_IDENT: begin
          close_vld  = 1'b1;
          close_kind = ident_kind(mask, seen);
        end
        MODE_STR: begin
          close_vld  = 1'b1;
          close_kind = TK_STRING;
          close_len  = str_len;
        end
        default: ;
      endcase
      idle_vld  = 1'b1;
      idle_kind = TK_EOF;
      idle_len  = '0;
      mode_next = MODE_IDLE;
      pos_next  = '0;
      tbeg_next = '0;
      mask_next = 3'b111;
      seen_next = '0;
      ovf_next  = 1'b0;
    end else begin
      pos_next = at_max ? pos : pos + 1'b1;
      ovf_next = ovf | at_max;
      rec_ovf  = ovf | at_max;
      case (mode)
        MODE_NUM: begin
          if (!is_digit(text_byte)) begin
            close_vld  = 1'b1;
            close_kind = TK_INT;
            run_idle   = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_alpha(text_byte) || is_digit(text_byte) || (text_byte == CH_UNDERSCORE)) begin
            mask_next = mask & ~kw_miss(seen, text_byte);
            seen_next = (seen < IDENT_SAT) ? seen + 1'b1 : seen;
          end else begin
            close_vld  = 1'b1;
            close_kind = ident_kind(mask, seen);
            mask_next  = 3'b111;
            seen_next  = '0;
            run_idle   = 1'b1;
          end
        end
        MODE_STR: begin
          if (text_byte == CH_QUOTE) begin
            close_vld  = 1'b1;
            close_kind = TK_STRING;
            close_len  = str_len;
            mode_next  = MODE_IDLE;
          end
        end
        MODE_COMMENT: begin
          if (text_byte == CH_NEWLINE) mode_next = MODE_IDLE;
        end
        MODE_HALT: ;
        default: run_idle = 1'b1;
      endcase
      if (run_idle) begin
        mode_next = MODE_IDLE;
        if (is_space(text_byte)) begin
          mode_next = MODE_IDLE;
        end else if (is_digit(text_byte)) begin
          mode_next = MODE_NUM;
          tbeg_next = pos;
        end else if (is_alpha(text_byte)) begin
          mode_next = MODE_IDENT;
          tbeg_next = pos;
          mask_next = ~kw_miss(3'd0, text_byte);
          seen_next = 3'd1;
        end else if (text_byte == CH_QUOTE) begin
          mode_next = MODE_STR;
          tbeg_next = at_max ? POS_MAX : pos + 1'b1;
        end else if (text_byte == CH_APOS) begin
          mode_next = MODE_COMMENT;
        end else begin
          idle_vld  = 1'b1;
          idle_kind = punct_kind(text_byte);
          if (idle_kind == TK_ERROR) mode_next = MODE_HALT;
        end
      end
    end
  end

  always_comb begin
    close_rec = '{kind: close_kind, start: to16(tbeg), length: to16(close_len),
                  ovf: rec_ovf, last: !idle_vld};
    idle_rec  = '{kind: idle_kind, start: to16(pos), length: to16(idle_len),
                  ovf: rec_ovf, last: 1'b1};
    if (close_vld) begin
      rec0 = close_rec;
      rec1 = idle_rec;
    end else begin
      rec0 = idle_rec;
      rec1 = close_rec;
    end
    if (!advance) push_n = 2'd0;
    else push_n = 2'({1'b0, close_vld}) + 2'({1'b0, idle_vld});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      pos  <= '0;
      tbeg <= '0;
      mask <= 3'b111;
      seen <= '0;
      ovf  <= 1'b0;
    end else if (advance) begin
      mode <= mode_next;
      pos  <= pos_next;
      tbeg <= tbeg_next;
      mask <= mask_next;
      seen <= seen_next;
      ovf  <= ovf_next;
    end
  end

  assign status = '{mode: mode, ovf: ovf};

endmodule

// File: rtl/bst_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_result_fifo
// Small result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module bst_result_fifo import bst_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               push_n,
  input  res_t                     d0,
  input  res_t                     d1,
  input  logic                     pop,
  output logic                     q_valid,
  output res_t                     q,
  output logic [FIFO_CNT_BITS-1:0] count
);

  res_t                     mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [FIFO_PTR_BITS-1:0] wr_ptr1;
  logic                     do_pop;

  assign q_valid = (count != '0);
  assign q       = mem[rd_ptr];
  assign do_pop  = pop && q_valid;
  assign wr_ptr1 = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr] <= d0;
    if (push_n == 2'd2) mem[wr_ptr1] <= d1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_BITS'(push_n);
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + FIFO_CNT_BITS'(push_n) - FIFO_CNT_BITS'(do_pop);
    end
  end

endmodule

// File: rtl/basic_source_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basic_source_tokenizer
// Byte-serial lexer for a small BASIC dialect: kind, start and length per token.
// ----------------------------------------------------------------------------
// One source byte (or an end-of-text mark) is taken per cycle, while in_ready
// is high, into an input register and lexed there; its zero, one or two results
// go into a four-entry result queue that hands out one result per cycle while
// out_ready is high. Items that give at most one result stream at one item per
// cycle when neither side stalls; an item that gives two results (a token closed
// by a punctuation or bad byte, or end of text flushing a pending token) is
// absorbed by the queue. The output port is the limit on sustained rate. An
// item's results pass through the input register and the result queue before
// they are valid. Input is taken whenever the queue holds at most two results.
// ----------------------------------------------------------------------------
module basic_source_tokenizer import bst_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic        position_overflow,
  output logic        last_of_run
);

  logic                     stg_valid;
  logic [7:0]               stg_byte;
  logic                     stg_eot;
  logic                     advance;
  logic [1:0]               push_n;
  res_t                     rec0, rec1, head;
  lex_status_t              status;
  logic [FIFO_CNT_BITS-1:0] fifo_count;

  assign advance  = stg_valid && (fifo_count <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
  assign in_ready = !stg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_byte <= text_byte;
      stg_eot  <= end_of_text;
    end
  end

  bst_lex_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .text_byte  (stg_byte),
    .end_of_text(stg_eot),
    .push_n     (push_n),
    .rec0       (rec0),
    .rec1       (rec1),
    .status     (status)
  );

  bst_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .d0     (rec0),
    .d1     (rec1),
    .pop    (out_ready),
    .q_valid(out_valid),
    .q      (head),
    .count  (fifo_count)
  );

  assign token_kind        = head.kind;
  assign token_start       = head.start;
  assign token_length      = head.length;
  assign position_overflow = head.ovf;
  assign last_of_run       = head.last;

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("result queue over capacity");

  a_eot_emits: assert property (@(posedge clk) disable iff (rst)
    (advance && stg_eot) |-> (push_n != 2'd0))
    else $error("end of text gave no result");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && stg_eot) |=> (status.mode == MODE_IDLE && !status.ovf))
    else $error("lexer state not cleared after end of text");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for basic_source_tokenizer.
// ----------------------------------------------------------------------------
// Source bytes are fed through the valid/ready input while the bench runs
// its own lexer alongside. That lexer keeps the mode, position and keyword
// tracking and queues the tokens that each accepted byte should produce.
// A checker compares every token handed out against the oldest queued one,
// field by field. Directed texts cover keywords, punctuation, string and
// comment endings and the halt on a bad byte. Random texts are mostly
// well-formed token streams with some noise, under changing idle patterns
// and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import bst_pkg::*;

  localparam int unsigned POS_TOP   = (1 << POSITION_BITS_DEF) - 1;
  localparam int          HOLD_LEN  = 400;
  localparam int          MAX_SHOWN = 10;

  typedef struct {
    tok_kind_t   kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        ovf;
    logic        last;
  } token_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  text_byte;
  logic        end_of_text;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        position_overflow;
  logic        last_of_run;

  basic_source_tokenizer dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .text_byte         (text_byte),
    .end_of_text       (end_of_text),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .token_kind        (token_kind),
    .token_start       (token_start),
    .token_length      (token_length),
    .position_overflow (position_overflow),
    .last_of_run       (last_of_run)
  );

  // lexer state
  mode_t       lx_mode;
  int unsigned lx_pos;
  int unsigned lx_begin;
  logic [2:0]  lx_kw;
  int unsigned lx_seen;
  logic        lx_ovf;

  token_t tok_buf[2];
  int     tok_n;
  token_t pending_tokens[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_asked;
  int err_count;
  int live_items;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------- lexer ----------------
  function automatic bit digit_ch(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit letter_ch(logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic bit blank_ch(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic string kw_text(int i);
    case (i)
      0:       return "DEF";
      1:       return "PRINT";
      default: return "IF";
    endcase
  endfunction

  function automatic tok_kind_t kw_tok(int i);
    case (i)
      0:       return TK_DEF;
      1:       return TK_PRINT;
      default: return TK_IF;
    endcase
  endfunction

  function automatic void lexer_clear();
    lx_mode  = MODE_IDLE;
    lx_pos   = 0;
    lx_begin = 0;
    lx_kw    = 3'b111;
    lx_seen  = 0;
    lx_ovf   = 1'b0;
  endfunction

  function automatic void emit(tok_kind_t k, int unsigned s, int unsigned len);
    token_t t;
    t.kind   = k;
    t.start  = s[15:0];
    t.length = len[15:0];
    t.ovf    = lx_ovf;
    t.last   = 1'b0;
    tok_buf[tok_n] = t;
    tok_n++;
  endfunction

  function automatic void word_char(logic [7:0] c);
    string w;
    for (int i = 0; i < 3; i++) begin
      w = kw_text(i);
      if (lx_seen >= w.len() || w[lx_seen] != c)
        lx_kw[i] = 1'b0;
    end
    if (lx_seen < 6)
      lx_seen++;
  endfunction

  function automatic void close_word(int unsigned stop);
    tok_kind_t k;
    string     w;
    k = TK_IDENT;
    for (int i = 0; i < 3; i++) begin
      w = kw_text(i);
      if (lx_kw[i] && lx_seen == w.len())
        k = kw_tok(i);
    end
    emit(k, lx_begin, stop - lx_begin);
    lx_kw   = 3'b111;
    lx_seen = 0;
  endfunction

  function automatic void lex_fresh(logic [7:0] c, int unsigned p);
    if (blank_ch(c)) begin
      return;
    end
    if (digit_ch(c)) begin
      lx_mode  = MODE_NUM;
      lx_begin = p;
      return;
    end
    if (letter_ch(c)) begin
      lx_mode  = MODE_IDENT;
      lx_begin = p;
      lx_kw    = 3'b111;
      lx_seen  = 0;
      word_char(c);
      return;
    end
    case (c)
      "=": emit(TK_ASSIGN, p, 1);
      "+": emit(TK_PLUS, p, 1);
      "-": emit(TK_MINUS, p, 1);
      "*": emit(TK_MUL, p, 1);
      "/": emit(TK_DIV, p, 1);
      "(": emit(TK_LPAREN, p, 1);
      ")": emit(TK_RPAREN, p, 1);
      ",": emit(TK_COMMA, p, 1);
      CH_QUOTE: begin
        lx_mode  = MODE_STR;
        lx_begin = (p < POS_TOP) ? p + 1 : POS_TOP;
      end
      CH_APOS: lx_mode = MODE_COMMENT;
      default: begin
        emit(TK_ERROR, p, 1);
        lx_mode = MODE_HALT;
      end
    endcase
  endfunction

  function automatic void lex_item(logic [7:0] c, logic eot);
    int unsigned p;
    token_t      t;
    tok_n = 0;
    p = lx_pos;
    if (eot) begin
      case (lx_mode)
        MODE_NUM:   emit(TK_INT, lx_begin, p - lx_begin);
        MODE_IDENT: close_word(p);
        MODE_STR:   emit(TK_STRING, lx_begin, (p >= lx_begin) ? p - lx_begin : 0);
        default: ;
      endcase
      emit(TK_EOF, p, 0);
      lexer_clear();
    end else begin
      if (lx_pos >= POS_TOP) begin
        lx_pos = POS_TOP;
        lx_ovf = 1'b1;
      end else begin
        lx_pos++;
      end
      case (lx_mode)
        MODE_NUM: begin
          if (!digit_ch(c)) begin
            emit(TK_INT, lx_begin, p - lx_begin);
            lx_mode = MODE_IDLE;
            lex_fresh(c, p);
          end
        end
        MODE_IDENT: begin
          if (letter_ch(c) || digit_ch(c) || c == CH_UNDERSCORE) begin
            word_char(c);
          end else begin
            close_word(p);
            lx_mode = MODE_IDLE;
            lex_fresh(c, p);
          end
        end
        MODE_STR: begin
          if (c == CH_QUOTE) begin
            emit(TK_STRING, lx_begin, (p >= lx_begin) ? p - lx_begin : 0);
            lx_mode = MODE_IDLE;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NEWLINE)
            lx_mode = MODE_IDLE;
        end
        MODE_HALT: ;
        default: lex_fresh(c, p);
      endcase
    end
    for (int i = 0; i < tok_n; i++) begin
      t = tok_buf[i];
      t.last = (i == tok_n - 1);
      pending_tokens.push_back(t);
    end
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    token_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("%0t: token with none pending: kind %0d start %0d len %0d",
                   $time, token_kind, token_start, token_length);
      end else begin
        want = pending_tokens.pop_front();
        if (token_kind !== want.kind || token_start !== want.start ||
            token_length !== want.length || position_overflow !== want.ovf ||
            last_of_run !== want.last) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display({"%0t: token mismatch (exp/got) kind %0d/%0d start %0d/%0d ",
                      "len %0d/%0d ovf %0b/%0b last %0b/%0b"}, $time,
                     want.kind, token_kind, want.start, token_start,
                     want.length, token_length, want.ovf, position_overflow,
                     want.last, last_of_run);
        end
      end
    end
  end

  // ---------------- output side ----------------
  initial begin : rx_side
    int served;
    served = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != served) begin
        served = hold_asked;
        out_ready <= 1'b0;
        repeat (HOLD_LEN - 1) @(posedge clk);
      end else begin
        out_ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------- input side ----------------
  task automatic send_item(logic [7:0] b, logic eot);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= b;
    end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (lx_mode != MODE_HALT)
      live_items++;
    lex_item(b, eot);
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b0);
  endtask

  task automatic send_eot();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic string near_word(int k);
    case (k)
      0:  return "DEF";
      1:  return "PRINT";
      2:  return "IF";
      3:  return "DE";
      4:  return "DEFF";
      5:  return "PRIN";
      6:  return "PRINTX";
      7:  return "I";
      8:  return "IFA";
      9:  return "def";
      10: return "Print";
      11: return "DEF_";
      12: return "IF9";
      default: return "PRINT1";
    endcase
  endfunction

  function automatic logic [7:0] punct_byte(int k);
    case (k)
      0: return "=";
      1: return "+";
      2: return "-";
      3: return "*";
      4: return "/";
      5: return "(";
      6: return ")";
      default: return ",";
    endcase
  endfunction

  function automatic logic [7:0] word_byte();
    int k;
    k = $urandom_range(62);
    if (k < 26) return 8'("A" + k);
    if (k < 52) return 8'("a" + k - 26);
    if (k < 62) return 8'("0" + k - 52);
    return CH_UNDERSCORE;
  endfunction

  task automatic send_text();
    int         ntok;
    int         pick;
    int         len;
    logic [7:0] b;
    ntok = $urandom_range(1, 10);
    repeat (ntok) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_item(8'($urandom_range(255)), 1'b0);
      end else if (pick < 22) begin
        send_str(near_word($urandom_range(13)));
      end else if (pick < 36) begin
        send_item(word_byte() | 8'h40 & 8'h7F ? 8'("A" + $urandom_range(25)) : 8'h41,
                  1'b0);
        len = $urandom_range(8);
        repeat (len) send_item(word_byte(), 1'b0);
      end else if (pick < 50) begin
        len = $urandom_range(1, 6);
        repeat (len) send_item(8'("0" + $urandom_range(9)), 1'b0);
      end else if (pick < 60) begin
        send_item(CH_QUOTE, 1'b0);
        len = $urandom_range(6);
        repeat (len) begin
          b = 8'($urandom_range(255));
          if (b == CH_QUOTE) b = 8'h00;
          send_item(b, 1'b0);
        end
        send_item(CH_QUOTE, 1'b0);
      end else if (pick < 67) begin
        send_item(CH_APOS, 1'b0);
        len = $urandom_range(6);
        repeat (len) begin
          b = 8'($urandom_range(255));
          if (b == CH_NEWLINE) b = 8'hFF;
          send_item(b, 1'b0);
        end
        send_item(CH_NEWLINE, 1'b0);
      end else begin
        send_item(punct_byte($urandom_range(7)), 1'b0);
      end
      if ($urandom_range(2) != 0)
        send_item(8'($urandom_range(1) ? CH_SPACE : CH_TAB + $urandom_range(4)), 1'b0);
    end
    if ($urandom_range(9) == 0) begin
      send_item($urandom_range(1) ? CH_QUOTE : CH_APOS, 1'b0);
      repeat ($urandom_range(3)) send_item(8'($urandom_range(255)), 1'b0);
    end
    send_eot();
  endtask

  // ---------------- tests ----------------
  task automatic test_keywords_and_punct();
    send_str("IF(DEF,PRINT)=9+x*1/-");
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_string_comment_ends();
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(CH_APOS, 1'b0);
    send_item(8'h00, 1'b0);
    send_eot();
  endtask

  task automatic test_error_halt();
    send_item(8'h00, 1'b0);
    send_item("a", 1'b0);
    send_eot();
    send_item(8'hFF, 1'b0);
    send_eot();
  endtask

  task automatic test_random_text(int target);
    int first;
    first = live_items;
    while (live_items - first < target)
      send_text();
  endtask

  task automatic test_rx_holdoff();
    hold_asked++;
    test_random_text(150);
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    text_byte   = 8'h00;
    end_of_text = 1'b0;
    tx_idle_pct = 14;
    rx_idle_pct = 78;
    hold_asked  = 0;
    err_count   = 0;
    live_items  = 0;
    lexer_clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_keywords_and_punct();
    test_string_comment_ends();
    test_error_halt();
    test_random_text(650);

    tx_idle_pct = 78;
    rx_idle_pct = 14;
    test_random_text(650);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_rx_holdoff();
    test_random_text(450);

    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: basic_source_tokenizer.f
rtl/bst_pkg.sv
rtl/bst_lex_core.sv
rtl/bst_result_fifo.sv
rtl/basic_source_tokenizer.sv
tb/testbench.sv
